// ===== src/huffman_merge_list_decoder_core_defines.svh =====
// assertion helpers shared by the decoder rtl
`ifndef HUFFMAN_MERGE_LIST_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_MERGE_LIST_DECODER_CORE_DEFINES_SVH

// condition must never hold outside reset
`define HMLD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define HMLD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/hmld_pkg.sv =====
`default_nettype none
package hmld_pkg;

  // default sizing
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int MAX_PAIRS_DEF   = 255;

  // fixed field widths
  localparam int FIELD_W       = 8;
  localparam int PAIR_COUNT_W  = 8;
  localparam int PIXEL_COUNT_W = 25;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd1;

  // input operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CODE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] pair_index;
    logic [FIELD_W-1:0] first_symbol;
    logic [FIELD_W-1:0] second_symbol;
    logic [FIELD_W-1:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] symbol;
    logic               last;
    logic               image_done;
  } out_item_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_CODE
  } cmd_kind_t;

  // classified beat handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic               idx_ok;
    logic [FIELD_W-1:0] pair_index;
    logic [FIELD_W-1:0] first_symbol;
    logic [FIELD_W-1:0] second_symbol;
    logic [FIELD_W-1:0] code_byte;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TOP_RD,
    BK_ROOT,
    BK_LEAF_A,
    BK_LEAF_B,
    BK_PAIR,
    BK_SCAN_RD,
    BK_SCAN_CMP,
    BK_SPLIT,
    BK_NEW_A,
    BK_NEW_B,
    BK_WALK_START,
    BK_WALK,
    BK_FLUSH
  } bk_state_t;

endpackage
`default_nettype wire

// ===== src/hmld_fifo.sv =====
`default_nettype none
module hmld_fifo
  import hmld_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== src/hmld_front.sv =====
`default_nettype none
module hmld_front
  import hmld_pkg::*;
#(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  input  wire logic     cmd_pop,
  output cmd_t          cmd,
  output logic          cmd_empty
);

  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  // classify the incoming beat
  always_comb begin
    cmd_in.kind          = (in_item.op == OP_LOAD) ? CMD_LOAD : CMD_CODE;
    cmd_in.idx_ok        = (32'(in_item.pair_index) < MAX_PAIRS);
    cmd_in.pair_index    = in_item.pair_index;
    cmd_in.first_symbol  = in_item.first_symbol;
    cmd_in.second_symbol = in_item.second_symbol;
    cmd_in.code_byte     = in_item.code_byte;
  end

  // short queue towards the back end
  hmld_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_raw),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_raw);

endmodule
`default_nettype wire

// ===== src/hmld_back.sv =====
`default_nettype none
module hmld_back
  import hmld_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int MAX_PAIRS   = MAX_PAIRS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [PIXEL_COUNT_W-1:0] cfg_data,
  input  wire cmd_t                     cmd,
  input  wire logic                     cmd_empty,
  output logic                          cmd_pop,
  output logic                          res_push,
  output out_item_t                     res_item,
  input  wire logic                     res_full
);

  localparam int NODE_COUNT = 2 * MAX_PAIRS + 2;
  localparam int NB         = $clog2(NODE_COUNT);
  localparam int PA_W       = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int NODE_W     = 1 + SYMBOL_BITS + 2 * NB;

  function automatic logic [SYMBOL_BITS-1:0] to_sym(input logic [FIELD_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[SYMBOL_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] from_sym(input logic [SYMBOL_BITS-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic [PA_W-1:0] to_pa(input logic [31:0] v);
    return v[PA_W-1:0];
  endfunction

  // merge list and node memories
  logic [FIELD_W-1:0] pf_mem [MAX_PAIRS];
  logic [FIELD_W-1:0] ps_mem [MAX_PAIRS];
  logic [NODE_W-1:0]  nd_mem [NODE_COUNT];

  logic               pm_we, pm_re;
  logic [PA_W-1:0]    pm_waddr, pm_raddr;
  logic [FIELD_W-1:0] pf_rd_r, ps_rd_r;
  logic               nm_we, nm_re;
  logic [NB-1:0]      nm_waddr, nm_raddr;
  logic [NODE_W-1:0]  nm_wdata, nm_rd_r;

  logic                   rd_leaf;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [NB-1:0]          rd_left, rd_right;

  assign rd_leaf  = nm_rd_r[NODE_W-1];
  assign rd_sym   = nm_rd_r[NODE_W-2 -: SYMBOL_BITS];
  assign rd_left  = nm_rd_r[2*NB-1:NB];
  assign rd_right = nm_rd_r[NB-1:0];

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pf_mem[pm_waddr] <= cmd.first_symbol;
      ps_mem[pm_waddr] <= cmd.second_symbol;
    end
    if (pm_re) begin
      pf_rd_r <= pf_mem[pm_raddr];
      ps_rd_r <= ps_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nd_mem[nm_waddr] <= nm_wdata;
    end
    if (nm_re) begin
      nm_rd_r <= nd_mem[nm_raddr];
    end
  end

  // control and datapath state
  bk_state_t                state_r, state_nxt;
  logic                     tree_ready_r, tree_ready_nxt;
  logic [PAIR_COUNT_W-1:0]  pair_count_r, pair_count_nxt;
  logic [PIXEL_COUNT_W-1:0] pixel_count_r, pixel_count_nxt;
  logic [NB-1:0]            nfree_r, nfree_nxt;
  logic [PA_W-1:0]          pidx_r, pidx_nxt;
  logic [NB-1:0]            k_r, k_nxt;
  logic [NB-1:0]            cur_l_r, cur_l_nxt;
  logic [NB-1:0]            cur_r_r, cur_r_nxt;
  logic [PIXEL_COUNT_W-1:0] sd_r, sd_nxt;
  logic [FIELD_W-1:0]       byte_r, byte_nxt;
  logic [2:0]               bit_r, bit_nxt;
  logic                     pend_v_r, pend_v_nxt;
  out_item_t                pend_r, pend_nxt;

  logic [31:0]   top32;
  logic          walk_stall;
  logic          walk_cont;
  logic [NB-1:0] wl_nxt, wr_nxt;
  logic [PIXEL_COUNT_W-1:0] wsd_nxt;

  // last pair slot after clamping pair_count
  always_comb begin
    logic [31:0] pc;
    pc = (pair_count_r == '0) ? 32'd1 : 32'(pair_count_r);
    if (pc > MAX_PAIRS) begin
      pc = MAX_PAIRS;
    end
    top32 = pc - 32'd1;
  end

  // one tree step from the node just read
  always_comb begin
    walk_stall = rd_leaf && pend_v_r && res_full;
    if (rd_leaf) begin
      wl_nxt  = NB'(1);
      wr_nxt  = NB'(2);
      wsd_nxt = sd_r + PIXEL_COUNT_W'(1);
    end else begin
      wl_nxt  = rd_left;
      wr_nxt  = rd_right;
      wsd_nxt = sd_r;
    end
    walk_cont = (bit_r != 3'd0) && (wsd_nxt < pixel_count_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && cmd.kind == CMD_CODE) begin
          state_nxt = tree_ready_r ? BK_WALK_START : BK_TOP_RD;
        end
      end
      BK_TOP_RD: state_nxt = BK_ROOT;
      BK_ROOT:   state_nxt = BK_LEAF_A;
      BK_LEAF_A: state_nxt = BK_LEAF_B;
      BK_LEAF_B: state_nxt = BK_PAIR;
      BK_PAIR: begin
        if (pidx_r == '0) begin
          state_nxt = BK_WALK_START;
        end else if (32'(nfree_r) + 32'd1 < NODE_COUNT) begin
          state_nxt = BK_SCAN_RD;
        end
      end
      BK_SCAN_RD:  state_nxt = (k_r >= nfree_r) ? BK_PAIR : BK_SCAN_CMP;
      BK_SCAN_CMP: begin
        state_nxt = (rd_leaf && rd_sym == to_sym(pf_rd_r)) ? BK_SPLIT : BK_SCAN_RD;
      end
      BK_SPLIT: state_nxt = BK_NEW_A;
      BK_NEW_A: state_nxt = BK_NEW_B;
      BK_NEW_B: state_nxt = BK_PAIR;
      BK_WALK_START: state_nxt = (sd_r >= pixel_count_r) ? BK_FLUSH : BK_WALK;
      BK_WALK: begin
        if (!walk_stall && !walk_cont) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!pend_v_r || !res_full) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // memory strobes, results and datapath updates
  always_comb begin
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res_item        = pend_r;
    pm_we           = 1'b0;
    pm_re           = 1'b0;
    pm_waddr        = to_pa(32'(cmd.pair_index));
    pm_raddr        = pidx_r - PA_W'(1);
    nm_we           = 1'b0;
    nm_re           = 1'b0;
    nm_waddr        = nfree_r;
    nm_raddr        = k_r;
    nm_wdata        = '0;
    tree_ready_nxt  = tree_ready_r;
    pair_count_nxt  = pair_count_r;
    pixel_count_nxt = pixel_count_r;
    nfree_nxt       = nfree_r;
    pidx_nxt        = pidx_r;
    k_nxt           = k_r;
    cur_l_nxt       = cur_l_r;
    cur_r_nxt       = cur_r_r;
    sd_nxt          = sd_r;
    byte_nxt        = byte_r;
    bit_nxt         = bit_r;
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_LOAD) begin
            pm_we          = cmd.idx_ok;
            tree_ready_nxt = 1'b0;
          end else begin
            byte_nxt = cmd.code_byte;
          end
        end
      end
      BK_TOP_RD: begin
        pm_re    = 1'b1;
        pm_raddr = to_pa(top32);
        pidx_nxt = to_pa(top32);
      end
      // root always points at nodes one and two
      BK_ROOT: begin
        nm_we    = 1'b1;
        nm_waddr = '0;
        nm_wdata = {1'b0, {SYMBOL_BITS{1'b0}}, NB'(1), NB'(2)};
      end
      BK_LEAF_A: begin
        nm_we    = 1'b1;
        nm_waddr = NB'(1);
        nm_wdata = {1'b1, to_sym(pf_rd_r), {(2*NB){1'b0}}};
      end
      BK_LEAF_B: begin
        nm_we     = 1'b1;
        nm_waddr  = NB'(2);
        nm_wdata  = {1'b1, to_sym(ps_rd_r), {(2*NB){1'b0}}};
        nfree_nxt = NB'(3);
      end
      // step back one pair, or finish the build
      BK_PAIR: begin
        if (pidx_r == '0) begin
          tree_ready_nxt = 1'b1;
          sd_nxt         = '0;
          cur_l_nxt      = NB'(1);
          cur_r_nxt      = NB'(2);
        end else begin
          pidx_nxt = pidx_r - PA_W'(1);
          if (32'(nfree_r) + 32'd1 < NODE_COUNT) begin
            pm_re = 1'b1;
            k_nxt = '0;
          end
        end
      end
      // linear search for the lowest leaf holding the first symbol
      BK_SCAN_RD: begin
        nm_re = (k_r < nfree_r);
      end
      BK_SCAN_CMP: begin
        if (!(rd_leaf && rd_sym == to_sym(pf_rd_r))) begin
          k_nxt = k_r + NB'(1);
        end
      end
      BK_SPLIT: begin
        nm_we    = 1'b1;
        nm_waddr = k_r;
        nm_wdata = {1'b0, {SYMBOL_BITS{1'b0}}, nfree_r, nfree_r + NB'(1)};
      end
      BK_NEW_A: begin
        nm_we    = 1'b1;
        nm_wdata = {1'b1, to_sym(pf_rd_r), {(2*NB){1'b0}}};
      end
      BK_NEW_B: begin
        nm_we     = 1'b1;
        nm_waddr  = nfree_r + NB'(1);
        nm_wdata  = {1'b1, to_sym(ps_rd_r), {(2*NB){1'b0}}};
        nfree_nxt = nfree_r + NB'(2);
      end
      // first bit of the byte
      BK_WALK_START: begin
        if (sd_r < pixel_count_r) begin
          nm_re    = 1'b1;
          nm_raddr = byte_r[7] ? cur_r_r : cur_l_r;
          bit_nxt  = 3'd7;
        end
      end
      // one bit per cycle unless a full result queue stalls; a leaf is held back until the next one is known
      BK_WALK: begin
        if (!walk_stall) begin
          cur_l_nxt = wl_nxt;
          cur_r_nxt = wr_nxt;
          sd_nxt    = wsd_nxt;
          if (rd_leaf) begin
            if (pend_v_r) begin
              res_push      = 1'b1;
              res_item      = pend_r;
              res_item.last = 1'b0;
            end
            pend_v_nxt          = 1'b1;
            pend_nxt.symbol     = from_sym(rd_sym);
            pend_nxt.last       = 1'b1;
            pend_nxt.image_done = (wsd_nxt == pixel_count_r);
          end
          if (walk_cont) begin
            bit_nxt  = bit_r - 3'd1;
            nm_re    = 1'b1;
            nm_raddr = byte_r[bit_r - 3'd1] ? wr_nxt : wl_nxt;
          end
        end
      end
      // the held symbol is the last of this byte
      BK_FLUSH: begin
        if (pend_v_r && !res_full) begin
          res_push      = 1'b1;
          res_item      = pend_r;
          res_item.last = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
    // register writes
    if (cfg_we) begin
      if (cfg_index == CFG_PAIR_COUNT) begin
        pair_count_nxt = cfg_data[PAIR_COUNT_W-1:0];
        tree_ready_nxt = 1'b0;
      end else if (cfg_index == CFG_PIXEL_COUNT) begin
        pixel_count_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      tree_ready_r  <= 1'b0;
      pair_count_r  <= PAIR_COUNT_W'(1);
      pixel_count_r <= PIXEL_COUNT_W'(1);
      nfree_r       <= NB'(1);
      sd_r          <= '0;
      cur_l_r       <= NB'(1);
      cur_r_r       <= NB'(2);
      pend_v_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      tree_ready_r  <= tree_ready_nxt;
      pair_count_r  <= pair_count_nxt;
      pixel_count_r <= pixel_count_nxt;
      nfree_r       <= nfree_nxt;
      sd_r          <= sd_nxt;
      cur_l_r       <= cur_l_nxt;
      cur_r_r       <= cur_r_nxt;
      pend_v_r      <= pend_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    k_r    <= k_nxt;
    byte_r <= byte_nxt;
    bit_r  <= bit_nxt;
    pend_r <= pend_nxt;
  end

endmodule
`default_nettype wire

// ===== src/huffman_merge_list_decoder_core.sv =====
`default_nettype none
// Huffman decoder driven by a merge list. Push merge pairs (op 0) and then code bytes (op 1);
// decoded symbols come out of the result queue, last marking the final symbol of each byte and
// image_done the symbol that reaches pixel_count. The first code byte after a pair load or a
// pair_count write rebuilds the tree: the last pair is read and the root and its two leaves
// written, then each earlier pair is read and the allocated nodes are probed in a linear
// search of the node memory for a leaf holding its first symbol; a hit writes three nodes.
// Once built, a byte is popped, its first node read is issued, and it walks one code bit per
// cycle through the node memory read port unless a leaf waits on a full result queue, then
// hands over its last symbol. A pair load is written to the merge list as it is popped. The
// user must write configuration only while the block is idle; the block does not enforce it.
module huffman_merge_list_decoder_core
  import hmld_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int MAX_PAIRS   = MAX_PAIRS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire in_item_t                 in_item,
  output logic                          full,
  output logic                          empty,
  input  wire logic                     pop,
  output out_item_t                     out_item,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [PIXEL_COUNT_W-1:0] cfg_data
);

`include "huffman_merge_list_decoder_core_defines.svh"

  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_item_t res_item;
  logic [$bits(out_item_t)-1:0] out_raw;

  // intake and classification
  hmld_front #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // tree build and walk
  hmld_back #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  // result queue
  hmld_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_item),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_raw),
    .empty (empty)
  );

  assign out_item = out_item_t'(out_raw);

  // checks
  `HMLD_ASSERT_NEVER(a_res_overflow, res_push && res_full, "result beat pushed into full queue")
  `HMLD_ASSERT_NEVER(a_cmd_underflow, cmd_pop && cmd_empty, "command popped from empty queue")
  `HMLD_ASSERT_IMPLY(a_done_is_last, !empty && out_item.image_done, out_item.last, "image_done without last")

endmodule
`default_nettype wire

// ===== tb/huffman_merge_list_decoder_core_tb.sv =====
`default_nettype none
module huffman_merge_list_decoder_core_tb;
  import hmld_pkg::*;

  localparam int NODES = 512;

  // decoder model and queue of expected symbol beats
  class huff_scoreboard;
    out_item_t symbol_q[$];
    int        mismatches;
    int        first_of[256];
    int        second_of[256];
    int        left_of[NODES];
    int        right_of[NODES];
    int        sym_of[NODES];
    bit        is_leaf[NODES];
    int        next_free;
    int        walk;
    int        decoded;
    bit        tree_ok;
    int        pair_cnt;
    int        pixel_cnt;

    function new();
      mismatches = 0;
      next_free  = 1;
      walk       = 0;
      decoded    = 0;
      tree_ok    = 0;
      pair_cnt   = 1;
      pixel_cnt  = 1;
      for (int i = 0; i < NODES; i++) begin
        left_of[i]  = 0;
        right_of[i] = 0;
        sym_of[i]   = 0;
        is_leaf[i]  = 0;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
      if (idx == CFG_PAIR_COUNT) begin
        pair_cnt = val & 8'hff;
        tree_ok  = 0;
      end else if (idx == CFG_PIXEL_COUNT) begin
        pixel_cnt = val & 25'h1ffffff;
      end
    endfunction

    // build the tree from the last pair backward
    function void rebuild_tree();
      int n;
      int fsym;
      int hit;
      n = pair_cnt;
      if (n == 0) n = 1;
      if (n > 255) n = 255;
      for (int i = 0; i < NODES; i++) begin
        left_of[i]  = 0;
        right_of[i] = 0;
        is_leaf[i]  = 0;
      end
      left_of[0]  = 1;
      right_of[0] = 2;
      is_leaf[1]  = 1;
      sym_of[1]   = first_of[n-1];
      is_leaf[2]  = 1;
      sym_of[2]   = second_of[n-1];
      next_free   = 3;
      for (int p = n - 2; p >= 0; p--) begin
        fsym = first_of[p];
        hit  = -1;
        for (int k = 0; k < next_free; k++) begin
          if (hit < 0 && is_leaf[k] && sym_of[k] == fsym) hit = k;
        end
        if (hit >= 0 && next_free + 1 < NODES) begin
          is_leaf[hit]  = 0;
          left_of[hit]  = next_free;
          right_of[hit] = next_free + 1;
          is_leaf[next_free]    = 1;
          sym_of[next_free]     = fsym;
          left_of[next_free]    = 0;
          right_of[next_free]   = 0;
          is_leaf[next_free+1]  = 1;
          sym_of[next_free+1]   = second_of[p];
          left_of[next_free+1]  = 0;
          right_of[next_free+1] = 0;
          next_free += 2;
        end
      end
      walk    = 0;
      decoded = 0;
      tree_ok = 1;
    endfunction

    // accepted input beat
    function void note_input(in_item_t it);
      int        child;
      int        produced;
      out_item_t r;
      if (it.op == OP_LOAD) begin
        if (it.pair_index < 255) begin
          first_of[it.pair_index]  = int'(it.first_symbol);
          second_of[it.pair_index] = int'(it.second_symbol);
        end
        tree_ok = 0;
        return;
      end
      if (!tree_ok) rebuild_tree();
      produced = 0;
      for (int b = 7; b >= 0; b--) begin
        if (decoded < pixel_cnt) begin
          child = it.code_byte[b] ? right_of[walk] : left_of[walk];
          if (is_leaf[child]) begin
            decoded = (decoded + 1) & 25'h1ffffff;
            r.symbol     = 8'(sym_of[child]);
            r.last       = 1'b0;
            r.image_done = (decoded == pixel_cnt);
            symbol_q.push_back(r);
            produced++;
            walk = 0;
          end else begin
            walk = child;
          end
        end
      end
      if (produced > 0) symbol_q[symbol_q.size()-1].last = 1'b1;
    endfunction

    // accepted result beat
    function void check_result(out_item_t got);
      out_item_t want;
      if (symbol_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected symbol beat %p", got);
        return;
      end
      want = symbol_q.pop_front();
      if (got.symbol !== want.symbol || got.last !== want.last ||
          got.image_done !== want.image_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("symbol beat mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     push = 1'b0;
  in_item_t                 in_item = '0;
  logic                     full;
  logic                     empty;
  logic                     pop = 1'b0;
  out_item_t                out_item;
  logic                     cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = CFG_PAIR_COUNT;
  logic [PIXEL_COUNT_W-1:0] cfg_data = '0;

  huff_scoreboard sb = new();
  int  items_sent = 0;
  bit  calm = 0;
  int  pop_hold = 0;

  huffman_merge_list_decoder_core uut (
    .clk(clk), .rst_n(rst_n), .push(push), .in_item(in_item), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input beat through the push handshake
  task automatic send(in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_load(int idx, int a, int b);
    in_item_t it;
    it = in_item_t'(33'({$urandom, $urandom}));
    it.op            = OP_LOAD;
    it.pair_index    = 8'(idx);
    it.first_symbol  = 8'(a);
    it.second_symbol = 8'(b);
    send(it);
  endtask

  task automatic send_code(int v);
    in_item_t it;
    it = in_item_t'(33'({$urandom, $urandom}));
    it.op        = OP_CODE;
    it.code_byte = 8'(v);
    send(it);
  endtask

  // drain results, then allow for a build or a silent byte still running
  task automatic settle();
    push <= 1'b0;
    while (sb.symbol_q.size() != 0) @(posedge clk);
    repeat (4 * sb.pair_cnt * sb.pair_cnt + 300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= PIXEL_COUNT_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // merge list with random content, chained so that most pairs split a leaf
  task automatic random_tree(int n, int pixels, int nbytes);
    int used[$];
    int a;
    int b;
    int fa[256];
    int sa[256];
    settle();
    write_reg(CFG_PAIR_COUNT, n);
    write_reg(CFG_PIXEL_COUNT, pixels);
    used = {};
    for (int p = n - 1; p >= 0; p--) begin
      if (p == n - 1 || $urandom_range(0, 9) == 0) a = $urandom_range(0, 255);
      else a = used[$urandom_range(0, used.size() - 1)];
      b = ($urandom_range(0, 7) == 0 && used.size() > 0) ?
          used[$urandom_range(0, used.size() - 1)] : $urandom_range(0, 255);
      used.push_back(a);
      used.push_back(b);
      fa[p] = a;
      sa[p] = b;
    end
    for (int p = 0; p < n; p++) send_load(p, fa[p], sa[p]);
    for (int i = 0; i < nbytes; i++) begin
      // occasional reload of a slot in use, or a beat to an ignored slot
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) send_load(255, $urandom_range(0, 255), $urandom_range(0, 255));
        else begin
          a = $urandom_range(0, n - 1);
          send_load(a, fa[a], $urandom_range(0, 255));
        end
      end
      send_code($urandom_range(0, 255));
    end
  endtask

  // result side with random pop gaps
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_item);
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else begin
      pop_hold <= pick_gap();
      pop      <= 1'b1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single pair tree, image of one pixel, ignored slot
    write_reg(CFG_PAIR_COUNT, 1);
    write_reg(CFG_PIXEL_COUNT, 1);
    send_load(0, 8'h00, 8'hff);
    send_load(255, 8'hff, 8'hff);
    send_code(8'h00);
    send_code(8'hff);

    // pair count zero acts as one, image of 16777216 pixels
    settle();
    write_reg(CFG_PIXEL_COUNT, 16777216);
    write_reg(CFG_PAIR_COUNT, 0);
    send_code(8'hff);
    send_code(8'h55);

    // duplicate leaves and an orphan pair
    settle();
    write_reg(CFG_PAIR_COUNT, 4);
    send_load(0, 8'hc8, 8'h01);
    send_load(1, 8'h07, 8'h08);
    send_load(2, 8'h07, 8'h09);
    send_load(3, 8'h07, 8'h07);
    send_code(8'h00);
    send_code(8'hff);
    send_code(8'ha5);
    send_code(8'h3c);

    // no pixels at all, then a pixel count change keeps the tree
    settle();
    write_reg(CFG_PIXEL_COUNT, 0);
    send_code(8'h0f);
    settle();
    write_reg(CFG_PIXEL_COUNT, 3);
    send_code(8'hf0);
    send_code(8'h81);

    // one long merge list, then mostly small trees
    random_tree(120, 16777216, 4);
    while (items_sent < 220) begin
      calm = ($urandom_range(0, 4) == 0);
      random_tree($urandom_range(1, 8),
                  $urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 100000,
                  $urandom_range(6, 20));
    end
    calm = 0;

    push <= 1'b0;
    while (sb.symbol_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.symbol_q.size() == 0) begin
      $display("huffman_merge_list_decoder_core_tb OK");
    end else begin
      $display("huffman_merge_list_decoder_core_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("huffman_merge_list_decoder_core_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
